// ----- rtl/assert_macros.svh -----
// Assertion macros used by the checker file of this project.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Clocked property that is switched off while the reset is asserted.
`define CARV_ASSERT(lbl, clk, rst_n, prop, msg) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Clocked property that is also checked around the reset edges.
`define CARV_ASSERT_ALWAYS(lbl, clk, prop, msg) \
	lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

// ----- rtl/carv_pkg.sv -----
// Package with the constants, register codes and state type of the comb/allpass reverb.
`timescale 1ns / 1ps
package carv_pkg;

	localparam int COMB_COUNT_DEF      = 4;
	localparam int ALLPASS_COUNT_DEF   = 4;
	localparam int MAX_COMB_LEN_DEF    = 2048;
	localparam int MAX_ALLPASS_LEN_DEF = 1024;
	localparam int SAMPLE_BITS_DEF     = 24;

	localparam int COMB_FIELD_W = 12;
	localparam int AP_FIELD_W   = 11;
	localparam int FEEDBACK_W   = 16;
	localparam int MIX_W        = 17;
	localparam int COMB_LENS_W  = 48;
	localparam int AP_LENS_W    = 44;
	localparam int CFG_DATA_W   = 48;
	localparam int CFG_INDEX_W  = 2;

	localparam logic [FEEDBACK_W-1:0] GAIN_BASE     = 16'd45875;
	localparam logic [FEEDBACK_W-1:0] FEEDBACK_MAX  = 16'd62259;
	localparam logic [MIX_W-1:0]      MIX_ONE       = 17'd65536;
	localparam logic [MIX_W-1:0]      WET_MIX_RESET = 17'd32768;

	typedef enum logic [CFG_INDEX_W-1:0] {
		REG_FEEDBACK      = 2'd0,
		REG_WET_MIX       = 2'd1,
		REG_COMB_LENGTHS  = 2'd2,
		REG_AP_LENGTHS    = 2'd3
	} cfg_reg_t;

	typedef enum logic [3:0] {
		ST_CLEAR,
		ST_IDLE,
		ST_COMB_RD,
		ST_COMB_MUL,
		ST_COMB_WR,
		ST_SUM,
		ST_AP_RD,
		ST_AP_WR,
		ST_MIX_MUL,
		ST_MIX_OUT
	} state_t;

endpackage

// ----- rtl/comb_allpass_reverb_unit.sv -----
// Schroeder-style reverb: parallel feedback combs, series allpasses and a dry/wet mix.
`timescale 1ns / 1ps
// How to use this block:
// Samples enter on the input channel (in_valid, in_stall, sample_in) and one mixed
// sample leaves on the output channel (out_valid, out_stall, sample_out) for every
// input transfer, in order. A transfer happens on a rising edge with valid high and
// stall low on that channel.
// The block works on one sample at a time. A sample walks through every comb with a
// read, a multiply and a write-back of the comb memory (only the read step when the
// comb length is zero), then a sum step, then through every allpass with a read and
// a write-back of the allpass memory (only the read step when skipped), then a mix
// multiply and a mix output step, in which the result is registered. A new sample
// is taken only after the previous one has left the mix output step.
// The result waits in an output register, so a new sample is taken while the old
// result is still stalled; the block only holds off at the end of the next sample
// if the old result has still not been taken.
// After reset both delay memories are cleared in a sweep of one entry per cycle over
// the longer of COMB_COUNT*MAX_COMB_LEN and ALLPASS_COUNT*MAX_ALLPASS_LEN entries (8192
// with the defaults); in_stall stays high meanwhile. Configuration writes
// (cfg_valid, cfg_index, cfg_data) are always ready and should be issued while no
// sample is in flight. Writing a length register restarts that bank's positions.
module comb_allpass_reverb_unit import carv_pkg::*; #(
	parameter int COMB_COUNT      = COMB_COUNT_DEF,
	parameter int ALLPASS_COUNT   = ALLPASS_COUNT_DEF,
	parameter int MAX_COMB_LEN    = MAX_COMB_LEN_DEF,
	parameter int MAX_ALLPASS_LEN = MAX_ALLPASS_LEN_DEF,
	parameter int SAMPLE_BITS     = SAMPLE_BITS_DEF
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          in_valid,
	output logic                          in_stall,
	input  logic signed [SAMPLE_BITS-1:0] sample_in,
	output logic                          out_valid,
	input  logic                          out_stall,
	output logic signed [SAMPLE_BITS-1:0] sample_out,
	input  logic                          cfg_valid,
	output logic                          cfg_ready,
	input  logic [CFG_INDEX_W-1:0]        cfg_index,
	input  logic [CFG_DATA_W-1:0]         cfg_data
);

	// Memory geometry. Each comb owns a region of MAX_COMB_LEN entries, each allpass
	// a region of MAX_ALLPASS_LEN entries.
	localparam int CDEPTH    = COMB_COUNT * MAX_COMB_LEN;
	localparam int ADEPTH    = ALLPASS_COUNT * MAX_ALLPASS_LEN;
	localparam int CA_W      = $clog2(CDEPTH);
	localparam int AA_W      = $clog2(ADEPTH);
	localparam int CPOS_W    = $clog2(MAX_COMB_LEN);
	localparam int APOS_W    = $clog2(MAX_ALLPASS_LEN);
	localparam int CLEN_W    = $clog2(MAX_COMB_LEN + 1);
	localparam int ALEN_W    = $clog2(MAX_ALLPASS_LEN + 1);
	localparam int CIDX_W    = (COMB_COUNT > 1) ? $clog2(COMB_COUNT) : 1;
	localparam int AIDX_W    = (ALLPASS_COUNT > 1) ? $clog2(ALLPASS_COUNT) : 1;
	localparam int CLR_DEPTH = (CDEPTH > ADEPTH) ? CDEPTH : ADEPTH;
	localparam int CLR_W     = $clog2(CLR_DEPTH);

	// Arithmetic widths. A comb product is sample times a 17-bit signed gain, a mix
	// product sample times an 18-bit signed weight; MACC_W holds every sum in flight.
	localparam int SB      = SAMPLE_BITS;
	localparam int SUM_W   = SB + 3;
	localparam int CPROD_W = SB + 17;
	localparam int MPROD_W = SB + 18;
	localparam int MACC_W  = SB + 19;

	localparam logic signed [SB-1:0]      SMAX      = {1'b0, {(SB-1){1'b1}}};
	localparam logic signed [SB-1:0]      SMIN      = {1'b1, {(SB-1){1'b0}}};
	localparam logic signed [CPROD_W-1:0] CPROD_HALF = CPROD_W'(32768);
	localparam logic signed [MACC_W-1:0]  MACC_HALF  = MACC_W'(32768);
	localparam logic signed [SUM_W-1:0]   SUM_TWO    = SUM_W'(2);
	localparam logic signed [SB:0]        ONE_X      = (SB+1)'(1);

	// Clamp a wide signed value to the sample range.
	function automatic logic signed [SB-1:0] sat_w(input logic signed [MACC_W-1:0] v);
		if (v > MACC_W'(SMAX)) begin
			return SMAX;
		end else if (v < MACC_W'(SMIN)) begin
			return SMIN;
		end else begin
			return v[SB-1:0];
		end
	endfunction

	// Configuration registers.
	logic [FEEDBACK_W-1:0]  feedback_q;
	logic [MIX_W-1:0]       wet_mix_q;
	logic [COMB_LENS_W-1:0] comb_lengths_q;
	logic [AP_LENS_W-1:0]   ap_lengths_q;
	logic                   cfg_we;

	// Sequencer state and per-sample working registers.
	state_t                     state_q, state_d;
	logic [CLR_W-1:0]           clr_cnt_q;
	logic [CIDX_W-1:0]          cidx_q;
	logic [AIDX_W-1:0]          aidx_q;
	logic [CPOS_W-1:0]          cpos_q [COMB_COUNT];
	logic [APOS_W-1:0]          apos_q [ALLPASS_COUNT];
	logic signed [SB-1:0]       dry_q;
	logic [FEEDBACK_W-1:0]      gain_q;
	logic [MIX_W-1:0]           mix_q;
	logic signed [SUM_W-1:0]    sum_q;
	logic signed [CPROD_W-1:0]  cprod_q;
	logic signed [SB-1:0]       x_q;
	logic signed [MPROD_W-1:0]  pdry_q;
	logic signed [MPROD_W-1:0]  pwet_q;
	logic signed [SB-1:0]       out_q;
	logic                       out_valid_q;

	// Delay memories.
	logic signed [SB-1:0] comb_mem [CDEPTH];
	logic signed [SB-1:0] ap_mem [ADEPTH];
	logic signed [SB-1:0] comb_rd_q;
	logic signed [SB-1:0] ap_rd_q;
	logic                 comb_re, comb_we, ap_re, ap_we;
	logic [CA_W-1:0]      comb_wa;
	logic [AA_W-1:0]      ap_wa;
	logic signed [SB-1:0] comb_wd, ap_wd;

	// Derived lengths, positions and addresses for the stage being worked on.
	logic [CLEN_W-1:0]          comb_len [COMB_COUNT];
	logic [ALEN_W-1:0]          ap_len [ALLPASS_COUNT];
	logic [COMB_FIELD_W-1:0]    comb_field [COMB_COUNT];
	logic [AP_FIELD_W-1:0]      ap_field [ALLPASS_COUNT];
	logic [CLEN_W-1:0]          cur_clen, cpos_inc;
	logic [ALEN_W-1:0]          cur_alen, apos_inc;
	logic [CPOS_W-1:0]          cur_cpos, next_cpos;
	logic [APOS_W-1:0]          cur_apos, next_apos;
	logic [CA_W-1:0]            comb_addr;
	logic [AA_W-1:0]            ap_addr;
	logic                       comb_last, ap_last, clr_last;
	logic                       out_free;
	logic [FEEDBACK_W-1:0]      fb_clamped;
	logic signed [CPROD_W-1:0]  cprod_rnd;
	logic signed [SB:0]         half_d, half_x;
	logic signed [MACC_W-1:0]   mix_acc;
	logic signed [SB-1:0]       mix_y;
	logic [MIX_W-1:0]           dry_weight;

	// ------------------------------------------------------------------
	// Configuration port. Writes are always taken; a length write restarts the
	// positions of its own bank (see the position registers below).
	// ------------------------------------------------------------------
	assign cfg_ready = 1'b1;
	assign cfg_we    = cfg_valid && cfg_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			feedback_q     <= '0;
			wet_mix_q      <= WET_MIX_RESET;
			comb_lengths_q <= '0;
			ap_lengths_q   <= '0;
		end else if (cfg_we) begin
			case (cfg_reg_t'(cfg_index))
				REG_FEEDBACK:     feedback_q     <= cfg_data[FEEDBACK_W-1:0];
				REG_WET_MIX:      wet_mix_q      <= cfg_data[MIX_W-1:0];
				REG_COMB_LENGTHS: comb_lengths_q <= cfg_data[COMB_LENS_W-1:0];
				REG_AP_LENGTHS:   ap_lengths_q   <= cfg_data[AP_LENS_W-1:0];
				default: ;
			endcase
		end
	end

	// Unpack the length fields and clamp each one to its region size.
	always_comb begin
		for (int i = 0; i < COMB_COUNT; i++) begin
			comb_field[i] = comb_lengths_q[COMB_FIELD_W*i +: COMB_FIELD_W];
			comb_len[i]   = (comb_field[i] > COMB_FIELD_W'(MAX_COMB_LEN)) ?
				CLEN_W'(MAX_COMB_LEN) : CLEN_W'(comb_field[i]);
		end
		for (int i = 0; i < ALLPASS_COUNT; i++) begin
			ap_field[i] = ap_lengths_q[AP_FIELD_W*i +: AP_FIELD_W];
			ap_len[i]   = (ap_field[i] > AP_FIELD_W'(MAX_ALLPASS_LEN)) ?
				ALEN_W'(MAX_ALLPASS_LEN) : ALEN_W'(ap_field[i]);
		end
	end

	// Current comb: a stale position past the length reads as zero, and the
	// position wraps to zero once it reaches the length.
	assign cur_clen  = comb_len[cidx_q];
	assign cur_cpos  = (CLEN_W'(cpos_q[cidx_q]) >= cur_clen) ? '0 : cpos_q[cidx_q];
	assign cpos_inc  = CLEN_W'(cur_cpos) + CLEN_W'(1);
	assign next_cpos = (cpos_inc >= cur_clen) ? '0 : cpos_inc[CPOS_W-1:0];
	assign comb_addr = CA_W'(cidx_q * MAX_COMB_LEN) + CA_W'(cur_cpos);
	assign comb_last = (cidx_q == CIDX_W'(COMB_COUNT - 1));

	assign cur_alen  = ap_len[aidx_q];
	assign cur_apos  = (ALEN_W'(apos_q[aidx_q]) >= cur_alen) ? '0 : apos_q[aidx_q];
	assign apos_inc  = ALEN_W'(cur_apos) + ALEN_W'(1);
	assign next_apos = (apos_inc >= cur_alen) ? '0 : apos_inc[APOS_W-1:0];
	assign ap_addr   = AA_W'(aidx_q * MAX_ALLPASS_LEN) + AA_W'(cur_apos);
	assign ap_last   = (aidx_q == AIDX_W'(ALLPASS_COUNT - 1));

	assign clr_last  = (clr_cnt_q == CLR_W'(CLR_DEPTH - 1));
	assign out_free  = !out_valid_q || !out_stall;

	// Arithmetic of the write-back and mix steps. Every halving and scaling rounds to
	// nearest with ties upward, which is an add of half an LSB and an arithmetic shift.
	assign fb_clamped = (feedback_q > FEEDBACK_MAX) ? FEEDBACK_MAX : feedback_q;
	assign cprod_rnd  = (cprod_q + CPROD_HALF) >>> 16;
	assign half_d     = ((SB+1)'(ap_rd_q) + ONE_X) >>> 1;
	assign half_x     = ((SB+1)'(x_q) + ONE_X) >>> 1;
	assign mix_acc    = (MACC_W'(pdry_q) + MACC_W'(pwet_q) + MACC_HALF) >>> 16;
	assign mix_y      = sat_w(mix_acc);
	assign dry_weight = MIX_ONE - mix_q;

	// ------------------------------------------------------------------
	// Sequencer
	// ------------------------------------------------------------------
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_CLEAR;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d  = state_q;
		in_stall = 1'b1;
		comb_re  = 1'b0;
		comb_we  = 1'b0;
		ap_re    = 1'b0;
		ap_we    = 1'b0;
		comb_wa  = comb_addr;
		ap_wa    = ap_addr;
		comb_wd  = sat_w(MACC_W'(dry_q) + MACC_W'(cprod_rnd));
		ap_wd    = sat_w(MACC_W'(x_q) + MACC_W'(half_d));
		case (state_q)
			ST_CLEAR: begin
				// Sweep both memories to zero, one entry of each per cycle until its depth is covered.
				comb_wa = clr_cnt_q[CA_W-1:0];
				ap_wa   = clr_cnt_q[AA_W-1:0];
				comb_wd = '0;
				ap_wd   = '0;
				comb_we = ({1'b0, clr_cnt_q} < (CLR_W+1)'(CDEPTH));
				ap_we   = ({1'b0, clr_cnt_q} < (CLR_W+1)'(ADEPTH));
				if (clr_last) begin
					state_d = ST_IDLE;
				end
			end
			ST_IDLE: begin
				in_stall = 1'b0;
				if (in_valid) begin
					state_d = ST_COMB_RD;
				end
			end
			ST_COMB_RD: begin
				if (cur_clen != '0) begin
					comb_re = 1'b1;
					state_d = ST_COMB_MUL;
				end else if (comb_last) begin
					state_d = ST_SUM;
				end
			end
			ST_COMB_MUL: begin
				state_d = ST_COMB_WR;
			end
			ST_COMB_WR: begin
				comb_we = 1'b1;
				state_d = comb_last ? ST_SUM : ST_COMB_RD;
			end
			ST_SUM: begin
				state_d = ST_AP_RD;
			end
			ST_AP_RD: begin
				if (cur_alen != '0) begin
					ap_re   = 1'b1;
					state_d = ST_AP_WR;
				end else if (ap_last) begin
					state_d = ST_MIX_MUL;
				end
			end
			ST_AP_WR: begin
				ap_we   = 1'b1;
				state_d = ap_last ? ST_MIX_MUL : ST_AP_RD;
			end
			ST_MIX_MUL: begin
				state_d = ST_MIX_OUT;
			end
			ST_MIX_OUT: begin
				// Hold here only while the previous result is still stalled.
				if (out_free) begin
					state_d = ST_IDLE;
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	// Clear sweep counter.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			clr_cnt_q <= '0;
		end else if (state_q == ST_CLEAR) begin
			clr_cnt_q <= clr_cnt_q + CLR_W'(1);
		end
	end

	// Stage indexes. A skipped stage is stepped over from its read state alone.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cidx_q <= '0;
			aidx_q <= '0;
		end else begin
			if (state_q == ST_IDLE) begin
				cidx_q <= '0;
				aidx_q <= '0;
			end
			if ((state_q == ST_COMB_WR || (state_q == ST_COMB_RD && cur_clen == '0))
				&& !comb_last) begin
				cidx_q <= cidx_q + CIDX_W'(1);
			end
			if ((state_q == ST_AP_WR || (state_q == ST_AP_RD && cur_alen == '0))
				&& !ap_last) begin
				aidx_q <= aidx_q + AIDX_W'(1);
			end
		end
	end

	// Read positions. A length write restarts its bank; otherwise a position moves
	// on when its stage writes back.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < COMB_COUNT; i++) begin
				cpos_q[i] <= '0;
			end
			for (int i = 0; i < ALLPASS_COUNT; i++) begin
				apos_q[i] <= '0;
			end
		end else begin
			if (cfg_we && cfg_reg_t'(cfg_index) == REG_COMB_LENGTHS) begin
				for (int i = 0; i < COMB_COUNT; i++) begin
					cpos_q[i] <= '0;
				end
			end else if (state_q == ST_COMB_WR) begin
				cpos_q[cidx_q] <= next_cpos;
			end
			if (cfg_we && cfg_reg_t'(cfg_index) == REG_AP_LENGTHS) begin
				for (int i = 0; i < ALLPASS_COUNT; i++) begin
					apos_q[i] <= '0;
				end
			end else if (state_q == ST_AP_WR) begin
				apos_q[aidx_q] <= next_apos;
			end
		end
	end

	// Delay memories: one write and one registered read per cycle each.
	always_ff @(posedge clk) begin
		if (comb_we) begin
			comb_mem[comb_wa] <= comb_wd;
		end
		if (comb_re) begin
			comb_rd_q <= comb_mem[comb_addr];
		end
	end

	always_ff @(posedge clk) begin
		if (ap_we) begin
			ap_mem[ap_wa] <= ap_wd;
		end
		if (ap_re) begin
			ap_rd_q <= ap_mem[ap_addr];
		end
	end

	// Per-sample datapath. The comb output is the delayed value itself, so the
	// running sum takes the read data while the feedback value is written back.
	always_ff @(posedge clk) begin
		case (state_q)
			ST_IDLE: begin
				if (in_valid) begin
					dry_q  <= sample_in;
					gain_q <= GAIN_BASE + (fb_clamped >> 2);
					mix_q  <= (wet_mix_q > MIX_ONE) ? MIX_ONE : wet_mix_q;
					sum_q  <= '0;
				end
			end
			ST_COMB_MUL: begin
				cprod_q <= comb_rd_q * $signed({1'b0, gain_q});
			end
			ST_COMB_WR: begin
				sum_q <= sum_q + SUM_W'(comb_rd_q);
			end
			ST_SUM: begin
				x_q <= sat_w(MACC_W'((sum_q + SUM_TWO) >>> 2));
			end
			ST_AP_WR: begin
				x_q <= sat_w(MACC_W'(ap_rd_q) - MACC_W'(half_x));
			end
			ST_MIX_MUL: begin
				pdry_q <= dry_q * $signed({1'b0, dry_weight});
				pwet_q <= x_q * $signed({1'b0, mix_q});
			end
			ST_MIX_OUT: begin
				if (out_free) begin
					out_q <= mix_y;
				end
			end
			default: ;
		endcase
	end

	// Output register handshake.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (state_q == ST_MIX_OUT && out_free) begin
			out_valid_q <= 1'b1;
		end else if (!out_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	assign out_valid  = out_valid_q;
	assign sample_out = out_q;

endmodule

// ----- rtl/carv_checker.sv -----
// Port-level checker for the comb/allpass reverb and its bind to the top level.
`timescale 1ns / 1ps
`include "assert_macros.svh"
module carv_checker import carv_pkg::*; #(
	parameter int SAMPLE_BITS = SAMPLE_BITS_DEF
) (
	input logic                          clk,
	input logic                          arst_n,
	input logic                          in_valid,
	input logic                          in_stall,
	input logic signed [SAMPLE_BITS-1:0] sample_in,
	input logic                          out_valid,
	input logic                          out_stall,
	input logic signed [SAMPLE_BITS-1:0] sample_out,
	input logic                          cfg_valid,
	input logic                          cfg_ready,
	input logic [CFG_INDEX_W-1:0]        cfg_index,
	input logic [CFG_DATA_W-1:0]         cfg_data
);

	// A stalled result stays offered and unchanged.
	`CARV_ASSERT(a_out_hold, clk, arst_n, out_valid && out_stall |=> out_valid && $stable(sample_out), "stalled result changed or vanished")

	// The block works on one sample at a time, so an input transfer closes the input.
	`CARV_ASSERT(a_one_in_flight, clk, arst_n, in_valid && !in_stall |=> in_stall, "second sample taken while one is in flight")

	// The memory clear after reset keeps the input closed as reset is released.
	`CARV_ASSERT_ALWAYS(a_clear_after_reset, clk, arst_n && !$past(arst_n) |-> in_stall, "input open before the memory clear")

	// Configuration writes are never held off.
	`CARV_ASSERT(a_cfg_ready, clk, arst_n, cfg_valid |-> cfg_ready, "configuration write held off")

endmodule

bind comb_allpass_reverb_unit carv_checker #(.SAMPLE_BITS(SAMPLE_BITS)) u_carv_checker (.*);

// ----- verif/tb_comb_allpass_reverb_unit.sv -----
// Self-checking testbench for the comb/allpass reverb unit with a built-in sample predictor.
`timescale 1ns / 1ps
module tb_comb_allpass_reverb_unit;
	import carv_pkg::*;

	// Sample type at the width of the block's sample ports.
	localparam int SB = SAMPLE_BITS_DEF;
	typedef logic signed [SB-1:0] smp_t;

	localparam smp_t SMP_MAX = 24'h7FFFFF;
	localparam smp_t SMP_MIN = 24'h800000;
	localparam longint SAT_HI = (longint'(1) << (SB - 1)) - 1;
	localparam longint SAT_LO = -SAT_HI - 1;

	// Random part: a number of configuration phases, each followed by a burst of samples.
	localparam int PHASES = 10;
	localparam int PHASE_ITEMS = 70;
	// Phase in which neither side idles at all.
	localparam int QUIET_PHASE = 4;
	// Phase in which the sender holds off halfway until the output has caught up.
	localparam int HOLD_PHASE = 2;

	// Clock, reset and the block's inputs, all known from time zero.
	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic in_valid = 1'b0;
	logic in_stall;
	smp_t sample_in = '0;
	logic out_valid;
	logic out_stall = 1'b0;
	smp_t sample_out;
	logic cfg_valid = 1'b0;
	logic cfg_ready;
	logic [CFG_INDEX_W-1:0] cfg_index = '0;
	logic [CFG_DATA_W-1:0] cfg_data = '0;

	// While set, the sender never pauses and the receiver never stalls.
	bit quiet = 1'b0;

	int errors = 0;
	int samples_sent = 0;
	int directed_sent = 0;
	int samples_checked = 0;
	int reg_writes = 0;

	// Output samples that the predictor has worked out and the block still owes.
	smp_t expected_samples[$];

	always #4 clk = ~clk;

	comb_allpass_reverb_unit DUT (
		.clk(clk),
		.arst_n(arst_n),
		.in_valid(in_valid),
		.in_stall(in_stall),
		.sample_in(sample_in),
		.out_valid(out_valid),
		.out_stall(out_stall),
		.sample_out(sample_out),
		.cfg_valid(cfg_valid),
		.cfg_ready(cfg_ready),
		.cfg_index(cfg_index),
		.cfg_data(cfg_data)
	);

	// ------------------------------------------------------------------
	// Predictor state: its own copy of the registers, the delay lines and
	// their positions. Everything starts as the block does after reset.
	// ------------------------------------------------------------------
	logic [FEEDBACK_W-1:0] fb_reg = '0;
	logic [MIX_W-1:0] mix_reg = WET_MIX_RESET;
	logic [COMB_LENS_W-1:0] comb_len_reg = '0;
	logic [AP_LENS_W-1:0] ap_len_reg = '0;
	smp_t comb_line [COMB_COUNT_DEF][MAX_COMB_LEN_DEF] = '{default: '0};
	smp_t ap_line [ALLPASS_COUNT_DEF][MAX_ALLPASS_LEN_DEF] = '{default: '0};
	int unsigned comb_pos [COMB_COUNT_DEF] = '{default: 0};
	int unsigned ap_pos [ALLPASS_COUNT_DEF] = '{default: 0};

	// Saturate to the signed sample range.
	function automatic longint clip(longint v);
		if (v > SAT_HI)
			return SAT_HI;
		if (v < SAT_LO)
			return SAT_LO;
		return v;
	endfunction

	// Divide by 2^s, rounding to nearest with ties going up. The arithmetic
	// shift of a signed value is a floor, which is exactly what is needed.
	function automatic longint rnd_shr(longint v, int s);
		return (v + (longint'(1) << (s - 1))) >>> s;
	endfunction

	// Register write as the block sees it. A length write restarts that bank's
	// positions but leaves the stored samples alone.
	function automatic void apply_register(cfg_reg_t idx, logic [CFG_DATA_W-1:0] v);
		case (idx)
			REG_FEEDBACK: fb_reg = v[FEEDBACK_W-1:0];
			REG_WET_MIX: mix_reg = v[MIX_W-1:0];
			REG_COMB_LENGTHS: begin
				comb_len_reg = v[COMB_LENS_W-1:0];
				comb_pos = '{default: 0};
			end
			REG_AP_LENGTHS: begin
				ap_len_reg = v[AP_LENS_W-1:0];
				ap_pos = '{default: 0};
			end
			default: ;
		endcase
	endfunction

	// Runs one dry sample through the combs, the allpass chain and the mix, updating
	// the delay lines, and returns the output sample the block must produce.
	function automatic smp_t reverb_sample(smp_t dry_in);
		longint dry, sum, x, d, acc;
		int unsigned fb, g, mix, len, p;
		dry = dry_in;
		fb = (fb_reg > FEEDBACK_MAX) ? FEEDBACK_MAX : fb_reg;
		g = GAIN_BASE + (fb >> 2);
		mix = (mix_reg > MIX_ONE) ? MIX_ONE : mix_reg;
		sum = 0;
		for (int i = 0; i < COMB_COUNT_DEF; i++) begin
			len = comb_len_reg[COMB_FIELD_W*i +: COMB_FIELD_W];
			if (len > MAX_COMB_LEN_DEF)
				len = MAX_COMB_LEN_DEF;
			if (len == 0)
				continue;
			p = (comb_pos[i] >= len) ? 0 : comb_pos[i];
			d = comb_line[i][p];
			comb_line[i][p] = smp_t'(clip(dry + rnd_shr(d * longint'(g), 16)));
			comb_pos[i] = (p + 1 >= len) ? 0 : p + 1;
			sum += d;
		end
		x = clip(rnd_shr(sum, 2));
		for (int i = 0; i < ALLPASS_COUNT_DEF; i++) begin
			len = ap_len_reg[AP_FIELD_W*i +: AP_FIELD_W];
			if (len > MAX_ALLPASS_LEN_DEF)
				len = MAX_ALLPASS_LEN_DEF;
			if (len == 0)
				continue;
			p = (ap_pos[i] >= len) ? 0 : ap_pos[i];
			d = ap_line[i][p];
			ap_line[i][p] = smp_t'(clip(x + rnd_shr(d, 1)));
			ap_pos[i] = (p + 1 >= len) ? 0 : p + 1;
			x = clip(d - rnd_shr(x, 1));
		end
		acc = dry * (longint'(MIX_ONE) - longint'(mix)) + x * longint'(mix);
		return smp_t'(clip(rnd_shr(acc, 16)));
	endfunction

	// ------------------------------------------------------------------
	// Output side: random stalls, and a check of every output transfer
	// against the oldest expectation. Values are taken as they stood just
	// before the edge, since the stall driver below updates nonblocking.
	// ------------------------------------------------------------------
	always @(posedge clk) begin
		out_stall <= !quiet && ($urandom_range(99) < 35);
	end

	always @(posedge clk) begin
		smp_t want;
		if (arst_n && out_valid === 1'b1 && !out_stall) begin
			if (expected_samples.size() == 0) begin
				$error("sample_out: transfer with no expectation waiting, got %0d", sample_out);
				errors++;
			end else begin
				want = expected_samples.pop_front();
				samples_checked++;
				if (sample_out !== want) begin
					$error("sample_out: expected %0d, actual %0d", want, sample_out);
					errors++;
				end
			end
		end
	end

	// ------------------------------------------------------------------
	// Input side.
	// ------------------------------------------------------------------

	// Stops sending and waits until the block has handed over every sample it owes.
	task automatic wait_for_drain();
		in_valid <= 1'b0;
		while (expected_samples.size() != 0)
			@(posedge clk);
	endtask

	// Writes one register once the block is idle. The write valid is left high after
	// the transfer; whatever comes next either writes again or lowers it in the same
	// step, so a write is never repeated by accident.
	task automatic write_register(cfg_reg_t idx, logic [CFG_DATA_W-1:0] v);
		wait_for_drain();
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data <= v;
		@(posedge clk);
		while (!cfg_ready)
			@(posedge clk);
		apply_register(idx, v);
		reg_writes++;
	endtask

	// Offers one sample, with random idle cycles ahead of it, and records what the
	// block must answer once the transfer has happened. For rows whose answer is
	// obvious the typed-in value is used, but the predictor still advances its state.
	task automatic push_sample(smp_t s, bit known, smp_t want);
		smp_t pred;
		cfg_valid <= 1'b0;
		if (!quiet) begin
			while ($urandom_range(99) < 35) begin
				in_valid <= 1'b0;
				@(posedge clk);
			end
		end
		in_valid <= 1'b1;
		sample_in <= s;
		@(posedge clk);
		while (in_stall)
			@(posedge clk);
		pred = reverb_sample(s);
		expected_samples.push_back(known ? want : pred);
		samples_sent++;
	endtask

	// Random sample, weighted toward the rails and toward tiny values where the
	// rounding of halves and quarters shows up.
	function automatic smp_t random_sample();
		case ($urandom_range(9))
			0: return SMP_MAX;
			1: return SMP_MIN;
			2: return smp_t'(int'($urandom_range(64)) - 32);
			default: return smp_t'($urandom);
		endcase
	endfunction

	// Random register value. Bits above the register width are filled with junk so
	// that the block is seen to ignore them. Lengths are mostly short so that the
	// delay lines wrap many times; now and then a stage is skipped, set to its
	// maximum, or set above the maximum.
	function automatic logic [CFG_DATA_W-1:0] random_register(cfg_reg_t idx);
		logic [CFG_DATA_W-1:0] v;
		int unsigned len;
		v = {$urandom, $urandom};
		case (idx)
			REG_FEEDBACK: begin
				case ($urandom_range(3))
					0: v[FEEDBACK_W-1:0] = '0;
					1: v[FEEDBACK_W-1:0] = FEEDBACK_MAX;
					2: v[FEEDBACK_W-1:0] = '1;
					default: v[FEEDBACK_W-1:0] = $urandom_range(65535);
				endcase
			end
			REG_WET_MIX: begin
				case ($urandom_range(4))
					0: v[MIX_W-1:0] = '0;
					1: v[MIX_W-1:0] = MIX_ONE;
					2: v[MIX_W-1:0] = '1;
					default: v[MIX_W-1:0] = $urandom_range(65536);
				endcase
			end
			REG_COMB_LENGTHS: begin
				for (int i = 0; i < COMB_COUNT_DEF; i++) begin
					case ($urandom_range(9))
						0: len = 0;
						1: len = MAX_COMB_LEN_DEF;
						2: len = $urandom_range(4095, MAX_COMB_LEN_DEF + 1);
						default: len = $urandom_range(24, 1);
					endcase
					v[COMB_FIELD_W*i +: COMB_FIELD_W] = len;
				end
			end
			REG_AP_LENGTHS: begin
				for (int i = 0; i < ALLPASS_COUNT_DEF; i++) begin
					case ($urandom_range(9))
						0: len = 0;
						1: len = MAX_ALLPASS_LEN_DEF;
						2: len = $urandom_range(2047, MAX_ALLPASS_LEN_DEF + 1);
						default: len = $urandom_range(16, 1);
					endcase
					v[AP_FIELD_W*i +: AP_FIELD_W] = len;
				end
			end
			default: ;
		endcase
		return v;
	endfunction

	// ------------------------------------------------------------------
	// Directed rows. Right after reset every stage has length zero, so the
	// wet path is silent and the output is half the dry sample, rounded with
	// ties up. With the mix at zero the dry sample comes straight through, and
	// with the mix clamped to full wet a silent chain gives zero. Once the
	// stages are switched on, the rows are checked against the predictor: the
	// combs run at the clamped top feedback with one length above the maximum,
	// one allpass is skipped and one is above its maximum, the rails drive the
	// stores into saturation, and at the end the combs are switched off while
	// the allpasses keep ringing with what they hold.
	// ------------------------------------------------------------------
	typedef struct {
		bit is_reg;
		cfg_reg_t reg_idx;
		logic [CFG_DATA_W-1:0] value;
		smp_t sample;
		bit known;
		smp_t want;
	} dir_row_t;

	dir_row_t dir_rows[] = '{
		'{1'b0, REG_FEEDBACK, 48'd0, 24'sd0, 1'b1, 24'sd0},
		'{1'b0, REG_FEEDBACK, 48'd0, SMP_MAX, 1'b1, 24'sh400000},
		'{1'b0, REG_FEEDBACK, 48'd0, SMP_MIN, 1'b1, 24'shC00000},
		'{1'b0, REG_FEEDBACK, 48'd0, 24'sd1, 1'b1, 24'sd1},
		'{1'b0, REG_FEEDBACK, 48'd0, -24'sd1, 1'b1, 24'sd0},
		'{1'b1, REG_WET_MIX, 48'd0, 24'sd0, 1'b0, 24'sd0},
		'{1'b0, REG_FEEDBACK, 48'd0, SMP_MAX, 1'b1, SMP_MAX},
		'{1'b0, REG_FEEDBACK, 48'd0, SMP_MIN, 1'b1, SMP_MIN},
		'{1'b0, REG_FEEDBACK, 48'd0, 24'sh5A5A5A, 1'b1, 24'sh5A5A5A},
		'{1'b1, REG_WET_MIX, 48'hFFFF_FFFF_FFFF, 24'sd0, 1'b0, 24'sd0},
		'{1'b0, REG_FEEDBACK, 48'd0, 24'shA5A5A5, 1'b1, 24'sd0},
		'{1'b1, REG_FEEDBACK, 48'hFFFF_FFFF_FFFF, 24'sd0, 1'b0, 24'sd0},
		'{1'b1, REG_COMB_LENGTHS, 48'h003_FFF_002_001, 24'sd0, 1'b0, 24'sd0},
		'{1'b1, REG_AP_LENGTHS, 48'h0005_FFC0_0001, 24'sd0, 1'b0, 24'sd0},
		'{1'b1, REG_WET_MIX, 48'd65536, 24'sd0, 1'b0, 24'sd0},
		'{1'b0, REG_FEEDBACK, 48'd0, SMP_MAX, 1'b0, 24'sd0},
		'{1'b0, REG_FEEDBACK, 48'd0, SMP_MAX, 1'b0, 24'sd0},
		'{1'b0, REG_FEEDBACK, 48'd0, SMP_MAX, 1'b0, 24'sd0},
		'{1'b0, REG_FEEDBACK, 48'd0, SMP_MIN, 1'b0, 24'sd0},
		'{1'b0, REG_FEEDBACK, 48'd0, SMP_MIN, 1'b0, 24'sd0},
		'{1'b0, REG_FEEDBACK, 48'd0, 24'sd0, 1'b0, 24'sd0},
		'{1'b0, REG_FEEDBACK, 48'd0, 24'sh123456, 1'b0, 24'sd0},
		'{1'b0, REG_FEEDBACK, 48'd0, SMP_MAX, 1'b0, 24'sd0},
		'{1'b1, REG_FEEDBACK, 48'd62259, 24'sd0, 1'b0, 24'sd0},
		'{1'b1, REG_WET_MIX, 48'd32768, 24'sd0, 1'b0, 24'sd0},
		'{1'b0, REG_FEEDBACK, 48'd0, SMP_MIN, 1'b0, 24'sd0},
		'{1'b0, REG_FEEDBACK, 48'd0, 24'sd1, 1'b0, 24'sd0},
		'{1'b0, REG_FEEDBACK, 48'd0, -24'sd1, 1'b0, 24'sd0},
		'{1'b1, REG_COMB_LENGTHS, 48'd0, 24'sd0, 1'b0, 24'sd0},
		'{1'b0, REG_FEEDBACK, 48'd0, SMP_MAX, 1'b0, 24'sd0},
		'{1'b0, REG_FEEDBACK, 48'd0, SMP_MIN, 1'b0, 24'sd0}
	};

	// ------------------------------------------------------------------
	// Main sequence.
	// ------------------------------------------------------------------
	initial begin
		// Reset is held low from time zero and then released. The block then clears its
		// delay memories and holds in_stall high for that sweep; the first transfer simply waits.
		repeat (2) @(posedge clk);
		arst_n <= 1'b1;

		foreach (dir_rows[k]) begin
			if (dir_rows[k].is_reg)
				write_register(dir_rows[k].reg_idx, dir_rows[k].value);
			else
				push_sample(dir_rows[k].sample, dir_rows[k].known, dir_rows[k].want);
		end
		directed_sent = samples_sent;

		// Each phase starts from an idle block with a fresh mix of settings. The
		// first phase rewrites every register; later ones leave some untouched, so
		// that delay positions carry over from one phase into the next and stores
		// left by earlier settings are read back under new lengths.
		for (int ph = 0; ph < PHASES; ph++) begin
			if (ph == 0 || $urandom_range(3) != 0)
				write_register(REG_FEEDBACK, random_register(REG_FEEDBACK));
			if (ph == 0 || $urandom_range(3) != 0)
				write_register(REG_WET_MIX, random_register(REG_WET_MIX));
			if (ph == 0 || $urandom_range(3) != 0)
				write_register(REG_COMB_LENGTHS, random_register(REG_COMB_LENGTHS));
			if (ph == 0 || $urandom_range(3) != 0)
				write_register(REG_AP_LENGTHS, random_register(REG_AP_LENGTHS));
			quiet = (ph == QUIET_PHASE);
			for (int n = 0; n < PHASE_ITEMS; n++) begin
				if (ph == HOLD_PHASE && n == PHASE_ITEMS / 2)
					wait_for_drain();
				push_sample(random_sample(), 1'b0, '0);
			end
		end
		quiet = 1'b0;

		// Let the last samples come out, then give the block time to show any
		// stray extra transfer.
		wait_for_drain();
		repeat (48) @(posedge clk);

		$display("Covered %0d samples (%0d directed) over %0d random phases, %0d register writes.",
			samples_sent, directed_sent, PHASES, reg_writes);
		$display("Compared %0d output samples, %0d failures.", samples_checked, errors);
		if (errors == 0)
			$display("PASS comb_allpass_reverb_unit");
		else
			$display("FAIL comb_allpass_reverb_unit");
		$finish;
	end

	// Watchdog: far beyond the slowest legal run, including the memory clear.
	initial begin
		#4_000_000;
		$display("FAIL comb_allpass_reverb_unit");
		$finish;
	end

endmodule
